>>> hw/rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths and register indexes of the biquad filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 32;
   localparam int DELAY_BITS_DEF  = 40;

   localparam int CSR_INDEX_BITS  = 3;

   // coefficient register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FEEDBACK_ONE = 3'd0,
      REG_FEEDBACK_TWO = 3'd1,
      REG_FORWARD_ZERO = 3'd2,
      REG_FORWARD_ONE  = 3'd3,
      REG_FORWARD_TWO  = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

>>> hw/rtl/bqf_req_if.sv
// ----------------------------------------------------------------------------
// bqf_req_if
// Sample input channel: valid/ready handshake carrying one audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqf_req_if #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bqf_rsp_if.sv
// ----------------------------------------------------------------------------
// bqf_rsp_if
// Filtered sample output channel: valid/ready handshake with clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqf_rsp_if #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_out;
   logic                   clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/biquad_iir_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Direct form II biquad with Q4.F coefficients, digit-serial multiply-add.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one signed sample per transaction, rsp returns the filtered
//   sample and a clip flag (delay word or output saturated in that step).
//   The five coefficients are written through csr_we/csr_index/csr_wdata while
//   the core is idle; the user must ensure this, the core does not enforce it. Unknown indexes are dropped.
// Timing:
//   every product runs through one shared multiply-add unit that consumes
//   the coefficient four bits per cycle, NDIG digits per product
//   (NDIG = ceil(COEF_BITS/4), 8 by default). One sample uses six products
//   (stability discriminant, two feedback, three feedforward) plus the check,
//   the saturations and the hand-off. One sample is in work at a time.
// Reset: synchronous; clears delay words and restores the default
//   coefficients (unity pass-through).
// Stall: the result sits in an output register; the next sample is taken
//   meanwhile and its computation waits at the end until rsp is free.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_core #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = bqf_pkg::COEF_BITS_DEF,
   parameter int DELAY_BITS  = bqf_pkg::DELAY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bqf_req_if.sink                                req,
   bqf_rsp_if.source                              rsp,
   input  wire logic                              csr_we,
   input  wire logic [bqf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]              csr_wdata
);
   import bqf_pkg::*;

   localparam int FRAC_BITS = COEF_BITS - 4;
   localparam int DIG       = 4;
   localparam int NDIG      = (COEF_BITS + DIG - 1) / DIG;
   localparam int CSH_BITS  = NDIG * DIG;
   localparam int CNT_BITS  = $clog2(NDIG);
   localparam int ACC_A     = COEF_BITS + DELAY_BITS + 2;
   localparam int ACC_B     = 2 * COEF_BITS + 1;
   localparam int ACC_BITS  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
   localparam int CHK_BITS  = COEF_BITS + 2;

   localparam logic [ACC_BITS-1:0]   HALF_LSB  = ACC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [COEF_BITS-1:0]  COEF_ONE  = COEF_BITS'(1) << FRAC_BITS;
   localparam logic [DELAY_BITS-1:0] W_MAX     = {1'b0, {(DELAY_BITS-1){1'b1}}};
   localparam logic [DELAY_BITS-1:0] W_MIN     = {1'b1, {(DELAY_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] Y_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] Y_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISC,
      ST_CHECK,
      ST_FB1,
      ST_FB2,
      ST_WSAT,
      ST_FF0,
      ST_FF1,
      ST_FF2,
      ST_YOUT
   } state_type;

   state_type                state_ff;
   logic [COEF_BITS-1:0]     fb1_ff, fb2_ff, ff0_ff, ff1_ff, ff2_ff;
   logic [DELAY_BITS-1:0]    w1_ff, w2_ff, w_ff;
   logic [SAMPLE_BITS-1:0]   x_ff;
   logic                     stable_ff;
   logic                     clip_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic signed [ACC_BITS-1:0] acc_ff, mcand_ff;
   logic signed [CSH_BITS-1:0] coef_sh_ff;
   logic                     rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]   rsp_sample_ff;
   logic                     rsp_clip_ff;

   // multiply-add datapath
   logic                       cnt_last;
   logic signed [DIG:0]        digit;
   logic signed [ACC_BITS+DIG:0] prod_full;
   logic signed [ACC_BITS-1:0] acc_in, mcand_in;
   logic signed [CSH_BITS-1:0] coef_sh_in;
   logic                       mul_busy;
   logic                       rsp_load;

   assign cnt_last   = (cnt_ff == CNT_BITS'(NDIG - 1));
   // top digit of the coefficient carries negative weight
   assign digit      = {(cnt_last ? coef_sh_ff[DIG-1] : 1'b0), coef_sh_ff[DIG-1:0]};
   assign prod_full  = mcand_ff * digit;
   assign acc_in     = acc_ff + $signed(prod_full[ACC_BITS-1:0]);
   assign mcand_in   = mcand_ff <<< DIG;
   assign coef_sh_in = coef_sh_ff >>> DIG;
   assign mul_busy   = (state_ff == ST_DISC) || (state_ff == ST_FB1) ||
                       (state_ff == ST_FB2)  || (state_ff == ST_FF0) ||
                       (state_ff == ST_FF1)  || (state_ff == ST_FF2);
   assign rsp_load   = (state_ff == ST_YOUT) && (!rsp_valid_ff || rsp.ready);

   // stability test on the coefficient registers, discriminant sign from acc
   logic signed [CHK_BITS-1:0] fb1_e, fb2_e, one_e, two_e, marg_a, marg_b;
   logic                       range_ok, fb2_ok, stable_in;

   assign fb1_e  = {{2{fb1_ff[COEF_BITS-1]}}, fb1_ff};
   assign fb2_e  = {{2{fb2_ff[COEF_BITS-1]}}, fb2_ff};
   assign one_e  = CHK_BITS'(1) << FRAC_BITS;
   assign two_e  = CHK_BITS'(1) << (FRAC_BITS + 1);
   assign marg_a = one_e - fb1_e - fb2_e;
   assign marg_b = one_e + fb1_e - fb2_e;
   assign range_ok = (fb1_e <= two_e) && (fb1_e >= -two_e) &&
                     !marg_a[CHK_BITS-1] && !marg_b[CHK_BITS-1];
   assign fb2_ok    = (fb2_e >= -one_e);
   assign stable_in = acc_ff[ACC_BITS-1] ? fb2_ok : range_ok;

   // rounding already folded into the accumulator start value
   logic [ACC_BITS-FRAC_BITS-DELAY_BITS:0]  w_hi;
   logic [ACC_BITS-FRAC_BITS-SAMPLE_BITS:0] y_hi;
   logic                     w_ovf, y_ovf;
   logic [DELAY_BITS-1:0]    w_sat;
   logic [SAMPLE_BITS-1:0]   y_sat;

   assign w_hi  = acc_ff[ACC_BITS-1:FRAC_BITS+DELAY_BITS-1];
   assign w_ovf = !((&w_hi) || !(|w_hi));
   assign w_sat = w_ovf ? (acc_ff[ACC_BITS-1] ? W_MIN : W_MAX)
                        : acc_ff[FRAC_BITS+DELAY_BITS-1:FRAC_BITS];
   assign y_hi  = acc_ff[ACC_BITS-1:FRAC_BITS+SAMPLE_BITS-1];
   assign y_ovf = !((&y_hi) || !(|y_hi));
   assign y_sat = y_ovf ? (acc_ff[ACC_BITS-1] ? Y_MIN : Y_MAX)
                        : acc_ff[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];

   function automatic logic signed [CSH_BITS-1:0] coef_ext(
      input logic [COEF_BITS-1:0] c,
      input logic                 en
   );
      logic signed [CSH_BITS-1:0] r;
      r = en ? $signed(CSH_BITS'($signed(c))) : '0;
      return r;
   endfunction

   function automatic logic signed [ACC_BITS-1:0] word_ext(
      input logic [DELAY_BITS-1:0] d
   );
      return {{(ACC_BITS-DELAY_BITS){d[DELAY_BITS-1]}}, d};
   endfunction

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.clipped    = rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fb1_ff       <= '0;
         fb2_ff       <= '0;
         ff0_ff       <= COEF_ONE;
         ff1_ff       <= '0;
         ff2_ff       <= '0;
         w1_ff        <= '0;
         w2_ff        <= '0;
         cnt_ff       <= '0;
         stable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FEEDBACK_ONE: fb1_ff <= csr_wdata;
               REG_FEEDBACK_TWO: fb2_ff <= csr_wdata;
               REG_FORWARD_ZERO: ff0_ff <= csr_wdata;
               REG_FORWARD_ONE:  ff1_ff <= csr_wdata;
               REG_FORWARD_TWO:  ff2_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mul_busy) begin
            acc_ff     <= acc_in;
            cnt_ff     <= cnt_last ? '0 : cnt_ff + CNT_BITS'(1);
            // on the last digit the operands are kept; any next operands are loaded below
            if (!cnt_last) begin
               mcand_ff   <= mcand_in;
               coef_sh_ff <= coef_sh_in;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  x_ff       <= req.sample_in;
                  // discriminant: fb1*fb1 + fb2*4*one
                  acc_ff     <= $signed(ACC_BITS'($signed(fb2_ff))) <<< (FRAC_BITS + 2);
                  mcand_ff   <= $signed(ACC_BITS'($signed(fb1_ff)));
                  coef_sh_ff <= coef_ext(fb1_ff, 1'b1);
                  cnt_ff     <= '0;
                  state_ff   <= ST_DISC;
               end
            end
            ST_DISC: begin
               if (cnt_last) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               stable_ff  <= stable_in;
               clip_ff    <= 1'b0;
               acc_ff     <= ($signed({{(ACC_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff})
                              <<< FRAC_BITS) | HALF_LSB;
               mcand_ff   <= word_ext(w1_ff);
               coef_sh_ff <= coef_ext(fb1_ff, stable_in);
               state_ff   <= ST_FB1;
            end
            ST_FB1: begin
               if (cnt_last) begin
                  mcand_ff   <= word_ext(w2_ff);
                  coef_sh_ff <= coef_ext(fb2_ff, stable_ff);
                  state_ff   <= ST_FB2;
               end
            end
            ST_FB2: begin
               if (cnt_last) begin
                  state_ff <= ST_WSAT;
               end
            end
            ST_WSAT: begin
               w_ff       <= w_sat;
               clip_ff    <= w_ovf;
               acc_ff     <= HALF_LSB;
               mcand_ff   <= word_ext(w_sat);
               coef_sh_ff <= coef_ext(ff0_ff, stable_ff);
               state_ff   <= ST_FF0;
            end
            ST_FF0: begin
               if (cnt_last) begin
                  mcand_ff   <= word_ext(w1_ff);
                  coef_sh_ff <= coef_ext(ff1_ff, stable_ff);
                  state_ff   <= ST_FF1;
               end
            end
            ST_FF1: begin
               if (cnt_last) begin
                  mcand_ff   <= word_ext(w2_ff);
                  coef_sh_ff <= coef_ext(ff2_ff, stable_ff);
                  state_ff   <= ST_FF2;
               end
            end
            ST_FF2: begin
               if (cnt_last) begin
                  state_ff <= ST_YOUT;
               end
            end
            ST_YOUT: begin
               // wait here while the previous transaction is still unread
               if (rsp_load) begin
                  rsp_sample_ff <= y_sat;
                  rsp_clip_ff   <= clip_ff | y_ovf;
                  rsp_valid_ff  <= 1'b1;
                  w2_ff         <= w1_ff;
                  w1_ff         <= w_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_yout: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_YOUT)
      else $error("result raised outside the output step");

   a_check_to_fb1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (state_ff == ST_FB1) && (cnt_ff == '0))
      else $error("feedback product did not start at digit zero");

   a_unstable_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FB1 && cnt_ff == '0 && !stable_ff) |-> coef_sh_ff == '0)
      else $error("unstable coefficients not forced to zero");

   a_delay_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff != ST_YOUT) |=> $stable(w1_ff) && $stable(w2_ff))
      else $error("delay words changed outside the output step");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for biquad_iir_filter_core. A cycle-free model of the
// direct form II datapath predicts every filtered sample and clip flag. A
// directed table is followed by randomly programmed coefficient phases and a
// closing run with a filter with a double pole at -1 that drives the delay words
// into saturation. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bqf_pkg::*;

   localparam int SB   = SAMPLE_BITS_DEF;
   localparam int CB   = COEF_BITS_DEF;
   localparam int DB   = DELAY_BITS_DEF;
   localparam int FRAC = CB - 4;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int RANDOM_ITEMS   = 380;
   localparam int RAMP_ITEMS     = 400;

   // Q4.28 coefficient codes
   localparam logic [CB-1:0] COEF_MAX     = 32'h7FFF_FFFF;
   localparam logic [CB-1:0] COEF_MIN     = 32'h8000_0000;
   localparam logic [CB-1:0] COEF_ZERO    = 32'h0000_0000;
   localparam logic [CB-1:0] COEF_ONE     = 32'h1000_0000;
   localparam logic [CB-1:0] COEF_NEG_ONE = 32'hF000_0000;
   localparam logic [CB-1:0] COEF_TWO     = 32'h2000_0000;
   localparam logic [CB-1:0] COEF_NEG_TWO = 32'hE000_0000;
   localparam int            ONE_INT      = 1 << FRAC;

   localparam logic [SB-1:0] SMP_MAX  = 24'h7F_FFFF;
   localparam logic [SB-1:0] SMP_MIN  = 24'h80_0000;
   localparam logic [SB-1:0] SMP_ZERO = 24'h00_0000;

   // indexes past the coefficient map
   localparam logic [CSR_INDEX_BITS-1:0] IDX_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_SPARE_HI = 3'd7;

   typedef logic signed [127:0] acc_type;

   typedef struct packed {
      logic [SB-1:0] sample_out;
      logic          clipped;
   } result_type;

   typedef struct packed {
      logic       typed;
      result_type res;
   } typed_out_type;

   typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CB-1:0]             data;
      logic [SB-1:0]             sample;
      logic                      typed;
      logic [SB-1:0]             want_out;
      logic                      want_clip;
   } stim_row_type;

   typedef enum logic [1:0] { PH_STABLE, PH_WILD, PH_EXTREME } phase_kind_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CB-1:0]             csr_wdata;

   bqf_req_if #(.SAMPLE_BITS(SB)) req_bus ();
   bqf_rsp_if #(.SAMPLE_BITS(SB)) rsp_bus ();

   biquad_iir_filter_core #(
      .SAMPLE_BITS (SB),
      .COEF_BITS   (CB),
      .DELAY_BITS  (DB)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter model state
   logic signed [CB-1:0] coef_reg [0:4];
   logic signed [DB-1:0] delay_one;
   logic signed [DB-1:0] delay_two;

   result_type    pending_out_q [$];
   typed_out_type typed_out_q [$];
   stim_row_type  dir_rows [$];

   int error_count;
   int items_sent;
   int results_checked;
   int clipped_seen;
   int unstable_steps;
   int config_writes;
   int quiet_cycles;
   bit idle_on;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic acc_type round_sat(acc_type acc, int bits, inout logic clip);
      acc_type r;
      acc_type top;
      acc_type bot;
      r   = (acc + (acc_type'(1) <<< (FRAC - 1))) >>> FRAC;
      top = (acc_type'(1) <<< (bits - 1)) - 1;
      bot = -(acc_type'(1) <<< (bits - 1));
      if (r > top) begin
         clip = 1'b1;
         return top;
      end
      if (r < bot) begin
         clip = 1'b1;
         return bot;
      end
      return r;
   endfunction

   // one sample through the biquad; advances the delay words
   function automatic result_type filter_step(logic [SB-1:0] x_raw);
      logic signed [SB-1:0] x_s;
      acc_type    x, one, disc, acc, w, y;
      acc_type    fb1, fb2, ff0, ff1, ff2, d1, d2;
      logic       clip;
      logic       stable;
      result_type res;
      x_s  = x_raw;
      x    = x_s;
      one  = acc_type'(1) <<< FRAC;
      fb1  = coef_reg[REG_FEEDBACK_ONE];
      fb2  = coef_reg[REG_FEEDBACK_TWO];
      ff0  = coef_reg[REG_FORWARD_ZERO];
      ff1  = coef_reg[REG_FORWARD_ONE];
      ff2  = coef_reg[REG_FORWARD_TWO];
      d1   = delay_one;
      d2   = delay_two;
      clip = 1'b0;
      disc = fb1 * fb1 + fb2 * 4 * one;
      if (disc < 0) begin
         stable = (fb2 >= -one);
      end else begin
         stable = (fb1 <= 2 * one) && (fb1 >= -2 * one) &&
                  (one - fb1 - fb2 >= 0) && (one + fb1 - fb2 >= 0);
      end
      // rejected coefficients act as all zero for this step
      if (!stable) begin
         fb1 = 0; fb2 = 0; ff0 = 0; ff1 = 0; ff2 = 0;
         unstable_steps++;
      end
      acc = x * one + fb1 * d1 + fb2 * d2;
      w   = round_sat(acc, DB, clip);
      acc = ff0 * w + ff1 * d1 + ff2 * d2;
      y   = round_sat(acc, SB, clip);
      delay_two      = delay_one;
      delay_one      = w[DB-1:0];
      res.sample_out = y[SB-1:0];
      res.clipped    = clip;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s at result %0d, got %h expected %h",
               what, results_checked, got, want);
      error_count++;
   endtask

   // transaction monitor, predictor update and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         coef_reg[REG_FEEDBACK_ONE] = COEF_ZERO;
         coef_reg[REG_FEEDBACK_TWO] = COEF_ZERO;
         coef_reg[REG_FORWARD_ZERO] = COEF_ONE;
         coef_reg[REG_FORWARD_ONE]  = COEF_ZERO;
         coef_reg[REG_FORWARD_TWO]  = COEF_ZERO;
         delay_one    = '0;
         delay_two    = '0;
         quiet_cycles = 0;
         pending_out_q.delete();
      end else begin
         quiet_cycles++;
         if (csr_we) begin
            if (csr_index <= REG_FORWARD_TWO) coef_reg[csr_index] = csr_wdata;
            config_writes++;
            quiet_cycles = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            result_type    pred;
            typed_out_type row;
            pred = filter_step(req_bus.sample_in);
            row  = '0;
            if (typed_out_q.size() != 0) row = typed_out_q.pop_front();
            pending_out_q.push_back(row.typed ? row.res : pred);
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_type want;
            quiet_cycles = 0;
            if (pending_out_q.size() == 0) begin
               report_mismatch("result with none pending", 32'(rsp_bus.sample_out), 32'd0);
            end else begin
               want = pending_out_q.pop_front();
               if (rsp_bus.sample_out !== want.sample_out)
                  report_mismatch("sample_out", 32'(rsp_bus.sample_out),
                                  32'(want.sample_out));
               if (rsp_bus.clipped !== want.clipped)
                  report_mismatch("clipped", 32'(rsp_bus.clipped), 32'(want.clipped));
            end
            if (rsp_bus.clipped === 1'b1) clipped_seen++;
            results_checked++;
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("biquad_iir_filter_core verification failed");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CB-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_sample(logic [SB-1:0] s, logic typed, logic [SB-1:0] want_out,
                              logic want_clip);
      int            bursts;
      typed_out_type row;
      bursts = 0;
      if (idle_on) begin
         while (bursts < 3 && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            bursts++;
         end
      end
      row.typed          = typed;
      row.res.sample_out = want_out;
      row.res.clipped    = want_clip;
      typed_out_q.push_back(row);
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // let every pending result come out before touching the registers
   task automatic drain_filter();
      req_bus.valid <= 1'b0;
      while (pending_out_q.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic stim_row_type wr_row(logic [CSR_INDEX_BITS-1:0] idx,
                                           logic [CB-1:0] val);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.data  = val;
      return r;
   endfunction

   function automatic stim_row_type smp_row(logic [SB-1:0] s);
      stim_row_type r;
      r        = '0;
      r.kind   = ROW_SAMPLE;
      r.sample = s;
      return r;
   endfunction

   function automatic stim_row_type chk_row(logic [SB-1:0] s, logic [SB-1:0] out,
                                            logic clip);
      stim_row_type r;
      r           = smp_row(s);
      r.typed     = 1'b1;
      r.want_out  = out;
      r.want_clip = clip;
      return r;
   endfunction

   function automatic logic [CB-1:0] coef_extreme();
      case ($urandom_range(0, 6))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return COEF_ZERO;
         3:       return COEF_ONE;
         4:       return COEF_NEG_ONE;
         5:       return COEF_TWO;
         default: return COEF_NEG_TWO;
      endcase
   endfunction

   // uniform in [-2, 2] in Q4.28, sometimes any code at all
   function automatic logic [CB-1:0] coef_forward();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return CB'(int'($urandom_range(0, 4 * ONE_INT)) - 2 * ONE_INT);
   endfunction

   function automatic logic [SB-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return SMP_MAX;
         1:       return SMP_MIN;
         2:       return SB'(int'($urandom_range(0, 511)) - 256);
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic program_phase(phase_kind_type kind);
      int            fb1;
      int            fb2;
      int            mag;
      logic [CB-1:0] v [0:4];
      case (kind)
         PH_STABLE: begin
            // feedback pair inside the stability triangle
            fb1  = int'($urandom_range(0, 4 * ONE_INT)) - 2 * ONE_INT;
            mag  = (fb1 < 0) ? -fb1 : fb1;
            fb2  = -ONE_INT + int'($urandom_range(0, 2 * ONE_INT - mag));
            v[0] = fb1;
            v[1] = fb2;
            v[2] = coef_forward();
            v[3] = coef_forward();
            v[4] = coef_forward();
         end
         PH_WILD: begin
            foreach (v[i]) v[i] = $urandom;
         end
         default: begin
            foreach (v[i]) v[i] = coef_extreme();
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), $urandom);
      write_reg(REG_FEEDBACK_ONE, v[0]);
      write_reg(REG_FEEDBACK_TWO, v[1]);
      write_reg(REG_FORWARD_ZERO, v[2]);
      write_reg(REG_FORWARD_ONE,  v[3]);
      write_reg(REG_FORWARD_TWO,  v[4]);
   endtask

   initial begin
      int             random_items;
      int             n;
      phase_kind_type kind;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      idle_on           = 1'b1;
      error_count       = 0;
      items_sent        = 0;
      results_checked   = 0;
      clipped_seen      = 0;
      unstable_steps    = 0;
      config_writes     = 0;
      quiet_cycles      = 0;
      random_items      = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unity pass-through after reset
      dir_rows.push_back(chk_row(SMP_ZERO, SMP_ZERO, 1'b0));
      dir_rows.push_back(chk_row(SMP_MAX, SMP_MAX, 1'b0));
      dir_rows.push_back(chk_row(SMP_MIN, SMP_MIN, 1'b0));
      dir_rows.push_back(chk_row(24'h00_0001, 24'h00_0001, 1'b0));
      dir_rows.push_back(chk_row(24'hFF_FFFF, 24'hFF_FFFF, 1'b0));
      // writes past the map change nothing
      dir_rows.push_back(wr_row(IDX_SPARE_LO, COEF_ZERO));
      dir_rows.push_back(wr_row(IDX_SPARE_HI, 32'hFFFF_FFFF));
      dir_rows.push_back(chk_row(24'h55_5555, 24'h55_5555, 1'b0));
      dir_rows.push_back(chk_row(24'hAA_AAAA, 24'hAA_AAAA, 1'b0));
      // output saturation with gain near +8 and -8
      dir_rows.push_back(wr_row(REG_FORWARD_ZERO, COEF_MAX));
      dir_rows.push_back(chk_row(SMP_MAX, SMP_MAX, 1'b1));
      dir_rows.push_back(chk_row(SMP_MIN, SMP_MIN, 1'b1));
      dir_rows.push_back(chk_row(SMP_ZERO, SMP_ZERO, 1'b0));
      dir_rows.push_back(wr_row(REG_FORWARD_ZERO, COEF_MIN));
      dir_rows.push_back(chk_row(SMP_MAX, SMP_MIN, 1'b1));
      dir_rows.push_back(chk_row(SMP_MIN, SMP_MAX, 1'b1));
      // rejected feedback: real poles outside, then complex poles too far out
      dir_rows.push_back(wr_row(REG_FORWARD_ZERO, COEF_ONE));
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_MAX));
      dir_rows.push_back(chk_row(24'h00_0100, SMP_ZERO, 1'b0));
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_MIN));
      dir_rows.push_back(chk_row(24'hFF_F000, SMP_ZERO, 1'b0));
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_ZERO));
      dir_rows.push_back(wr_row(REG_FEEDBACK_TWO, COEF_MIN));
      dir_rows.push_back(chk_row(24'h12_3456, SMP_ZERO, 1'b0));
      // complex poles on the unit circle
      dir_rows.push_back(wr_row(REG_FEEDBACK_TWO, COEF_NEG_ONE));
      dir_rows.push_back(smp_row(24'h10_0000));
      dir_rows.push_back(smp_row(SMP_ZERO));
      dir_rows.push_back(smp_row(SMP_ZERO));
      // double real pole at the edge, then one code past it
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_TWO));
      dir_rows.push_back(wr_row(REG_FORWARD_ONE, 32'hF800_0000));
      dir_rows.push_back(wr_row(REG_FORWARD_TWO, 32'h0400_0000));
      dir_rows.push_back(smp_row(24'h00_1000));
      dir_rows.push_back(smp_row(24'h00_1000));
      dir_rows.push_back(smp_row(SMP_MAX));
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_TWO + 1));
      dir_rows.push_back(chk_row(24'h00_0500, SMP_ZERO, 1'b0));
      // back to pass-through, old delay words no longer reach the output
      dir_rows.push_back(wr_row(REG_FEEDBACK_ONE, COEF_ZERO));
      dir_rows.push_back(wr_row(REG_FEEDBACK_TWO, COEF_ZERO));
      dir_rows.push_back(wr_row(REG_FORWARD_ONE, COEF_ZERO));
      dir_rows.push_back(wr_row(REG_FORWARD_TWO, COEF_ZERO));
      dir_rows.push_back(chk_row(24'hFA_CADE, 24'hFA_CADE, 1'b0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            drain_filter();
            write_reg(dir_rows[i].index, dir_rows[i].data);
         end else begin
            send_sample(dir_rows[i].sample, dir_rows[i].typed,
                        dir_rows[i].want_out, dir_rows[i].want_clip);
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         drain_filter();
         case ($urandom_range(0, 7))
            0:       kind = PH_WILD;
            1:       kind = PH_EXTREME;
            default: kind = PH_STABLE;
         endcase
         program_phase(kind);
         idle_on <= ($urandom_range(0, 3) != 0);
         n = $urandom_range(8, 40);
         repeat (n) send_sample(rand_sample(), 1'b0, SMP_ZERO, 1'b0);
         random_items += n;
      end

      // double pole at -1 fed with a full-scale alternating input: the
      // delay words grow until they pin at both rails
      drain_filter();
      write_reg(REG_FEEDBACK_ONE, COEF_NEG_TWO);
      write_reg(REG_FEEDBACK_TWO, COEF_NEG_ONE);
      write_reg(REG_FORWARD_ZERO, CB'(int'($urandom_range(0, 4 * ONE_INT)) - 2 * ONE_INT));
      write_reg(REG_FORWARD_ONE, CB'(int'($urandom_range(0, 4 * ONE_INT)) - 2 * ONE_INT));
      write_reg(REG_FORWARD_TWO, CB'(int'($urandom_range(0, 4 * ONE_INT)) - 2 * ONE_INT));
      idle_on <= 1'b0;
      for (int k = 0; k < RAMP_ITEMS; k++) begin
         if (k % 2 == 0) send_sample(SMP_MAX - SB'($urandom_range(0, 255)), 1'b0,
                                     SMP_ZERO, 1'b0);
         else            send_sample(SMP_MIN + SB'($urandom_range(0, 255)), 1'b0,
                                     SMP_ZERO, 1'b0);
      end

      drain_filter();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d samples and %0d checked outputs, %0d of them clipped",
               items_sent, results_checked, clipped_seen);
      $display("%0d steps ran with rejected coefficients, %0d register writes",
               unstable_steps, config_writes);
      if (error_count == 0) begin
         $display("biquad_iir_filter_core verification clean");
      end else begin
         $display("biquad_iir_filter_core verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_req_if.sv
hw/rtl/bqf_rsp_if.sv
hw/rtl/biquad_iir_filter_core.sv
sim/tb.sv
